// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the superoperator block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define OSA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Checks that a condition is followed by another after the delay given by dly.
`define OSA_ASSERT_DELAY(lbl, ante, cons, dly) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ## dly (cons)) \
      else $error("%m: delayed check failed");

`endif

// File: sv/osa_pkg.sv
// Types, constants and register codes of the one-qubit superoperator block.
package osa_pkg;

   localparam int SampleW   = 16;
   localparam int CoefW     = 16;
   localparam int ProdW     = SampleW + CoefW;
   localparam int AccW      = ProdW + 3;
   localparam int FracShift = 14;
   localparam int QuotW     = AccW - FracShift;
   localparam int Rows      = 4;
   localparam int GroupW    = 18;
   localparam int IdxW      = 20;
   localparam int CntW      = 4;
   localparam int PosW      = 5;
   localparam int CsrW      = 64;
   localparam int CsrIdxW   = 3;

   localparam int MaxQubitsDefault = 10;

   localparam logic signed [AccW-1:0] RoundBias = AccW'(1 << (FracShift - 1));

   localparam logic [CsrW-1:0] Row0Reset = 64'h0000_0000_0000_4000;
   localparam logic [CsrW-1:0] Row1Reset = 64'h0000_0000_4000_0000;
   localparam logic [CsrW-1:0] Row2Reset = 64'h0000_4000_0000_0000;
   localparam logic [CsrW-1:0] Row3Reset = 64'h4000_0000_0000_0000;
   localparam logic [CntW-1:0] TargetReset = 4'd0;
   localparam logic [CntW-1:0] CountReset  = 4'd10;

   typedef logic signed [SampleW-1:0] sample_type;
   typedef logic signed [CoefW-1:0]   coef_type;
   typedef logic [IdxW-1:0]           index_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ROW0   = 3'd0,
      CSR_ROW1   = 3'd1,
      CSR_ROW2   = 3'd2,
      CSR_ROW3   = 3'd3,
      CSR_TARGET = 3'd4,
      CSR_COUNT  = 3'd5
   } csr_reg_type;

   // Raw qubit settings handed to the address generator.
   typedef struct packed {
      logic [CntW-1:0] target;
      logic [CntW-1:0] count;
   } addr_cfg_type;

endpackage

// File: sv/osa_lane.sv
// One coefficient row times four samples: multiply, sum, round and saturate.
module osa_lane (
   input  logic                 clock,
   input  osa_pkg::coef_type    coef [osa_pkg::Rows],
   input  osa_pkg::sample_type  sample [osa_pkg::Rows],
   output osa_pkg::sample_type  result
);

   logic signed [osa_pkg::ProdW-1:0]  prod_ff [osa_pkg::Rows];
   logic signed [osa_pkg::AccW-1:0]   acc_ff;
   logic signed [osa_pkg::AccW-1:0]   acc_in;
   logic signed [osa_pkg::QuotW-1:0]  quot;
   osa_pkg::sample_type               result_ff;
   osa_pkg::sample_type               result_in;

   always_ff @(posedge clock) begin
      for (int j = 0; j < osa_pkg::Rows; j++) begin
         prod_ff[j] <= coef[j] * sample[j];
      end
   end

   always_comb begin
      acc_in = osa_pkg::RoundBias;
      for (int j = 0; j < osa_pkg::Rows; j++) begin
         acc_in = acc_in + osa_pkg::AccW'(prod_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // The arithmetic shift floors, so together with the bias this rounds half up.
   assign quot = $signed(acc_ff[osa_pkg::AccW-1:osa_pkg::FracShift]);

   always_comb begin
      if (quot[osa_pkg::QuotW-1:osa_pkg::SampleW-1] == '0 ||
          quot[osa_pkg::QuotW-1:osa_pkg::SampleW-1] == '1) begin
         result_in = quot[osa_pkg::SampleW-1:0];
      end else if (quot[osa_pkg::QuotW-1]) begin
         result_in = {1'b1, {(osa_pkg::SampleW-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(osa_pkg::SampleW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// File: sv/osa_addr.sv
// Address generator: clamps the qubit settings and inserts the two target bits.
module osa_addr #(
   parameter int MAX_QUBITS = osa_pkg::MaxQubitsDefault
) (
   input  logic                         clock,
   input  osa_pkg::addr_cfg_type        cfg,
   input  logic [osa_pkg::GroupW-1:0]   group_index,
   output osa_pkg::index_type           index_a,
   output osa_pkg::index_type           index_b,
   output osa_pkg::index_type           index_c,
   output osa_pkg::index_type           index_d
);

   localparam int AddrW = 2 * MAX_QUBITS;

   function automatic logic [AddrW-1:0] insert_zero(input logic [AddrW-1:0] x,
                                                    input logic [osa_pkg::PosW-1:0] pos);
      logic [AddrW-1:0] low;
      low = x & ~({AddrW{1'b1}} << pos);
      return ((x >> pos) << (pos + osa_pkg::PosW'(1))) | low;
   endfunction

   logic [osa_pkg::CntW-1:0]  n_eff;
   logic [osa_pkg::CntW-1:0]  t_eff;
   logic [osa_pkg::PosW-1:0]  gbits;
   logic [AddrW-1:0]          g_masked;

   logic [AddrW-1:0]          x1_ff;
   logic [osa_pkg::PosW-1:0]  inner_pos_ff;
   logic [osa_pkg::PosW-1:0]  outer_pos_ff;
   logic [AddrW-1:0]          ia_ff;
   logic [AddrW-1:0]          inner_ff;
   logic [AddrW-1:0]          outer_ff;
   osa_pkg::index_type        index_a_ff;
   osa_pkg::index_type        index_b_ff;
   osa_pkg::index_type        index_c_ff;
   osa_pkg::index_type        index_d_ff;

   always_comb begin
      if (cfg.count == '0) begin
         n_eff = osa_pkg::CntW'(1);
      end else if (cfg.count > osa_pkg::CntW'(MAX_QUBITS)) begin
         n_eff = osa_pkg::CntW'(MAX_QUBITS);
      end else begin
         n_eff = cfg.count;
      end
      if (cfg.target >= n_eff) begin
         t_eff = n_eff - osa_pkg::CntW'(1);
      end else begin
         t_eff = cfg.target;
      end
      // The quartet number has 2n-2 meaningful bits; the rest wraps away.
      gbits    = (osa_pkg::PosW'(n_eff) << 1) - osa_pkg::PosW'(2);
      g_masked = AddrW'(group_index) & ~({AddrW{1'b1}} << gbits);
   end

   always_ff @(posedge clock) begin
      x1_ff        <= insert_zero(g_masked, osa_pkg::PosW'(t_eff));
      inner_pos_ff <= osa_pkg::PosW'(t_eff);
      outer_pos_ff <= osa_pkg::PosW'(t_eff) + osa_pkg::PosW'(n_eff);
   end

   always_ff @(posedge clock) begin
      ia_ff    <= insert_zero(x1_ff, outer_pos_ff);
      inner_ff <= AddrW'(1) << inner_pos_ff;
      outer_ff <= AddrW'(1) << outer_pos_ff;
   end

   always_ff @(posedge clock) begin
      index_a_ff <= osa_pkg::IdxW'(ia_ff);
      index_b_ff <= osa_pkg::IdxW'(ia_ff | inner_ff);
      index_c_ff <= osa_pkg::IdxW'(ia_ff | outer_ff);
      index_d_ff <= osa_pkg::IdxW'(ia_ff | inner_ff | outer_ff);
   end

   assign index_a = index_a_ff;
   assign index_b = index_b_ff;
   assign index_c = index_c_ff;
   assign index_d = index_d_ff;

endmodule

// File: sv/one_qubit_superoperator_apply.sv
// Top level of the one-qubit superoperator block for flattened density matrices.
//
// A request is one quartet: its number and the four complex entries at its addresses.
// It is taken at a rising edge with start high and busy low; busy is high only
// during reset, so a new request can be taken in every cycle.
// Each request yields one result: four addresses and the four rows of the real
// 4x4 coefficient matrix applied to the real and to the imaginary parts.
// The result sits on the rsp_ ports for exactly one cycle with rsp_valid high.
// Latency is set by the input register, the multiplier register, the adder
// register and the round and saturate register; throughput is one request per cycle.
// The receiver cannot hold results off, so the pipeline never stalls.
// Registers are written through the csr_ port whenever csr_write_en is high outside reset and
// must only change while no request is in flight.
// Reset clears the pipeline valid bits and loads the identity matrix, target
// qubit 0 and a qubit count of 10.
`include "assert_macros.svh"

module one_qubit_superoperator_apply #(
   parameter int MAX_QUBITS = osa_pkg::MaxQubitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [osa_pkg::GroupW-1:0]    req_group_index,
   input  osa_pkg::sample_type           req_a_re,
   input  osa_pkg::sample_type           req_a_im,
   input  osa_pkg::sample_type           req_b_re,
   input  osa_pkg::sample_type           req_b_im,
   input  osa_pkg::sample_type           req_c_re,
   input  osa_pkg::sample_type           req_c_im,
   input  osa_pkg::sample_type           req_d_re,
   input  osa_pkg::sample_type           req_d_im,
   input  logic                          req_last_group,
   output logic                          rsp_valid,
   output osa_pkg::index_type            rsp_index_a,
   output osa_pkg::index_type            rsp_index_b,
   output osa_pkg::index_type            rsp_index_c,
   output osa_pkg::index_type            rsp_index_d,
   output osa_pkg::sample_type           rsp_new_a_re,
   output osa_pkg::sample_type           rsp_new_a_im,
   output osa_pkg::sample_type           rsp_new_b_re,
   output osa_pkg::sample_type           rsp_new_b_im,
   output osa_pkg::sample_type           rsp_new_c_re,
   output osa_pkg::sample_type           rsp_new_c_im,
   output osa_pkg::sample_type           rsp_new_d_re,
   output osa_pkg::sample_type           rsp_new_d_im,
   input  logic                          csr_write_en,
   input  logic [osa_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [osa_pkg::CsrW-1:0]      csr_wdata
);

   logic                            accept;
   logic [osa_pkg::CsrW-1:0]        row_ff [osa_pkg::Rows];
   logic [osa_pkg::CsrW-1:0]        row_in [osa_pkg::Rows];
   logic [osa_pkg::CntW-1:0]        target_ff;
   logic [osa_pkg::CntW-1:0]        target_in;
   logic [osa_pkg::CntW-1:0]        count_ff;
   logic [osa_pkg::CntW-1:0]        count_in;
   osa_pkg::addr_cfg_type           addr_cfg;

   logic                            v0_ff, v1_ff, v2_ff, v3_ff;
   logic [osa_pkg::GroupW-1:0]      group_ff;
   osa_pkg::sample_type             re_ff [osa_pkg::Rows];
   osa_pkg::sample_type             im_ff [osa_pkg::Rows];
   osa_pkg::coef_type               coef [osa_pkg::Rows][osa_pkg::Rows];
   osa_pkg::sample_type             new_re [osa_pkg::Rows];
   osa_pkg::sample_type             new_im [osa_pkg::Rows];

   assign busy   = reset;
   assign accept = start && !busy;

   // Register file.
   always_comb begin
      row_in    = row_ff;
      target_in = target_ff;
      count_in  = count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            osa_pkg::CSR_ROW0:   row_in[0] = csr_wdata;
            osa_pkg::CSR_ROW1:   row_in[1] = csr_wdata;
            osa_pkg::CSR_ROW2:   row_in[2] = csr_wdata;
            osa_pkg::CSR_ROW3:   row_in[3] = csr_wdata;
            osa_pkg::CSR_TARGET: target_in = csr_wdata[osa_pkg::CntW-1:0];
            osa_pkg::CSR_COUNT:  count_in  = csr_wdata[osa_pkg::CntW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= osa_pkg::Row0Reset;
         row_ff[1] <= osa_pkg::Row1Reset;
         row_ff[2] <= osa_pkg::Row2Reset;
         row_ff[3] <= osa_pkg::Row3Reset;
         target_ff <= osa_pkg::TargetReset;
         count_ff  <= osa_pkg::CountReset;
      end else begin
         row_ff    <= row_in;
         target_ff <= target_in;
         count_ff  <= count_in;
      end
   end

   assign addr_cfg.target = target_ff;
   assign addr_cfg.count  = count_ff;

   always_comb begin
      for (int r = 0; r < osa_pkg::Rows; r++) begin
         for (int j = 0; j < osa_pkg::Rows; j++) begin
            coef[r][j] = row_ff[r][osa_pkg::CoefW*j +: osa_pkg::CoefW];
         end
      end
   end

   // Valid bits travel alongside the input, product, sum and output stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         group_ff <= req_group_index;
         re_ff[0] <= req_a_re;
         re_ff[1] <= req_b_re;
         re_ff[2] <= req_c_re;
         re_ff[3] <= req_d_re;
         im_ff[0] <= req_a_im;
         im_ff[1] <= req_b_im;
         im_ff[2] <= req_c_im;
         im_ff[3] <= req_d_im;
      end
   end

   osa_addr #(
      .MAX_QUBITS (MAX_QUBITS)
   ) u_addr (
      .clock       (clock),
      .cfg         (addr_cfg),
      .group_index (group_ff),
      .index_a     (rsp_index_a),
      .index_b     (rsp_index_b),
      .index_c     (rsp_index_c),
      .index_d     (rsp_index_d)
   );

   for (genvar r = 0; r < osa_pkg::Rows; r++) begin : g_row
      osa_lane u_lane_re (
         .clock  (clock),
         .coef   (coef[r]),
         .sample (re_ff),
         .result (new_re[r])
      );
      osa_lane u_lane_im (
         .clock  (clock),
         .coef   (coef[r]),
         .sample (im_ff),
         .result (new_im[r])
      );
   end

   assign rsp_valid    = v3_ff;
   assign rsp_new_a_re = new_re[0];
   assign rsp_new_a_im = new_im[0];
   assign rsp_new_b_re = new_re[1];
   assign rsp_new_b_im = new_im[1];
   assign rsp_new_c_re = new_re[2];
   assign rsp_new_c_im = new_im[2];
   assign rsp_new_d_re = new_re[3];
   assign rsp_new_d_im = new_im[3];

   // Every accepted request comes out as a valid result, and every valid result comes from an accepted request.
   `OSA_ASSERT_DELAY(a_req_to_rsp, accept, rsp_valid, 4)
   `OSA_ASSERT_IMPL(a_rsp_from_req, rsp_valid, $past(accept, 4))
   // The four addresses differ only in the two target bits.
   `OSA_ASSERT_IMPL(a_index_shape, rsp_valid,
      (rsp_index_d == (rsp_index_b | rsp_index_c)) &&
      ((rsp_index_a & rsp_index_d) == rsp_index_a) && (rsp_index_b != rsp_index_c))

endmodule
